// File: rtl/ihc_pkg.sv
// Shared types and constants for the IPv4 header check unit.
`timescale 1ns / 1ps

package ihc_pkg;

   localparam int unsigned DATA_WIDTH      = 32;
   localparam int unsigned CSR_ADDR_WIDTH  = 3;
   localparam int unsigned POS_WIDTH       = 6;
   localparam int unsigned IHL_WIDTH       = 4;
   localparam int unsigned SUM_WIDTH       = 16;

   localparam logic [3:0]  IP_VERSION      = 4'd4;
   localparam logic [3:0]  MIN_IHL         = 4'd5;
   localparam logic [23:0] BCAST_MASK      = 24'hffffff;

   localparam logic [POS_WIDTH-1:0] POS_TTL     = 6'd8;
   localparam logic [POS_WIDTH-1:0] POS_CSUM_HI = 6'd10;
   localparam logic [POS_WIDTH-1:0] POS_CSUM_LO = 6'd11;
   localparam logic [POS_WIDTH-1:0] POS_DEST_LO = 6'd16;
   localparam logic [POS_WIDTH-1:0] POS_DEST_HI = 6'd19;
   localparam logic [POS_WIDTH-2:0] WORD_CSUM   = 5'd5;

   typedef enum logic [2:0] {
      VERDICT_DELIVER = 3'd0,
      VERDICT_VERSION = 3'd1,
      VERDICT_HEADLEN = 3'd2,
      VERDICT_TTL     = 3'd3,
      VERDICT_DEST    = 3'd4,
      VERDICT_CSUM    = 3'd5
   } verdict_type;

   typedef enum logic [0:0] {
      CSR_LOCAL_ADDRESS = 1'b0
   } csr_index_type;

   function automatic logic [SUM_WIDTH-1:0] oc_add(input logic [SUM_WIDTH-1:0] a,
                                                   input logic [SUM_WIDTH-1:0] b);
      logic [SUM_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_WIDTH-1:0] + {{(SUM_WIDTH-1){1'b0}}, s[SUM_WIDTH]};
   endfunction

endpackage

// File: rtl/ihc_req_if.sv
// Input channel carrying one packet byte per word.
`timescale 1ns / 1ps

interface ihc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] header_byte;
   logic       first_byte;

   modport source (output valid, output header_byte, output first_byte, input ready);
   modport sink   (input valid, input header_byte, input first_byte, output ready);
endinterface

// File: rtl/ihc_rsp_if.sv
// Result channel carrying one verdict per word.
`timescale 1ns / 1ps

interface ihc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] verdict;

   modport source (output valid, output verdict, input ready);
   modport sink   (input valid, input verdict, output ready);
endinterface

// File: rtl/ipv4_header_check_unit.sv
// IPv4 header check unit: version, length, TTL, destination and checksum checks.
// An accepted byte goes through the input register, then its verdict into the verdict register.
// Throughput: one byte per cycle while the verdict output is not stalled; the checksum adder
// with end-around carry sits between the input register and the verdict register.
// Reset: synchronous, active high; clears all header state, local_address and both valids.
`timescale 1ns / 1ps

module ipv4_header_check_unit
   import ihc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   ihc_req_if.sink                   req_chan,
   ihc_rsp_if.source                 rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [DATA_WIDTH-1:0]     csr_pwdata,
   output logic [DATA_WIDTH-1:0]     csr_prdata,
   output logic                      csr_pready
);

   logic [DATA_WIDTH-1:0] local_address_ff;
   logic                  csr_write;
   logic                  csr_hit;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;

   logic       out_valid_ff, out_valid_in;
   verdict_type verdict_ff, verdict_in;

   logic [POS_WIDTH-1:0] byte_pos_ff, byte_pos_in;
   logic [IHL_WIDTH-1:0] header_words_ff, header_words_in;
   logic [SUM_WIDTH-1:0] sum_ff, sum_in;
   logic [7:0]           high_byte_ff, high_byte_in;
   logic [SUM_WIDTH-1:0] csum_ff, csum_in;
   logic [31:0]          dest_ff, dest_in;
   logic                 ttl_zero_ff, ttl_zero_in;
   logic                 in_header_ff, in_header_in;

   logic out_free;
   logic advance;
   logic emit;
   logic last_byte;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_WIDTH-1] == CSR_LOCAL_ADDRESS);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready & csr_hit;
   assign csr_prdata = csr_hit ? local_address_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_address_ff <= '0;
      end else if (csr_write) begin
         local_address_ff <= csr_pwdata;
      end
   end

   assign out_free       = ~out_valid_ff | rsp_chan.ready;
   assign advance        = in_valid_ff & out_free;
   assign req_chan.ready = ~reset & (~in_valid_ff | out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready & req_chan.valid) begin
         in_byte_ff  <= req_chan.header_byte;
         in_first_ff <= req_chan.first_byte;
      end
   end

   assign last_byte = ({1'b0, byte_pos_ff} + 7'd1) >= {1'b0, header_words_ff, 2'b00};

   always_comb begin
      byte_pos_in     = byte_pos_ff;
      header_words_in = header_words_ff;
      sum_in          = sum_ff;
      high_byte_in    = high_byte_ff;
      csum_in         = csum_ff;
      dest_in         = dest_ff;
      ttl_zero_in     = ttl_zero_ff;
      in_header_in    = in_header_ff;
      emit            = 1'b0;
      verdict_in      = VERDICT_DELIVER;

      if (in_first_ff) begin
         in_header_in    = 1'b0;
         byte_pos_in     = '0;
         sum_in          = '0;
         csum_in         = '0;
         dest_in         = '0;
         ttl_zero_in     = 1'b0;
         high_byte_in    = '0;
         header_words_in = '0;
         if (in_byte_ff[7:4] != IP_VERSION) begin
            emit       = 1'b1;
            verdict_in = VERDICT_VERSION;
         end else if (in_byte_ff[3:0] < MIN_IHL) begin
            emit       = 1'b1;
            verdict_in = VERDICT_HEADLEN;
         end else begin
            header_words_in = in_byte_ff[3:0];
            high_byte_in    = in_byte_ff;
            byte_pos_in     = 6'd1;
            in_header_in    = 1'b1;
         end
      end else if (in_header_ff) begin
         if (byte_pos_ff == POS_TTL) begin
            ttl_zero_in = (in_byte_ff == 8'd0);
         end
         if (byte_pos_ff == POS_CSUM_HI) begin
            csum_in = {in_byte_ff, csum_ff[7:0]};
         end
         if (byte_pos_ff == POS_CSUM_LO) begin
            csum_in = {csum_ff[15:8], in_byte_ff};
         end
         if (byte_pos_ff >= POS_DEST_LO && byte_pos_ff <= POS_DEST_HI) begin
            dest_in = {dest_ff[23:0], in_byte_ff};
         end
         if (!byte_pos_ff[0]) begin
            high_byte_in = in_byte_ff;
         end else if (byte_pos_ff[POS_WIDTH-1:1] != WORD_CSUM) begin
            sum_in = oc_add(sum_ff, {high_byte_ff, in_byte_ff});
         end
         if (last_byte) begin
            in_header_in = 1'b0;
            byte_pos_in  = '0;
            emit         = 1'b1;
            if (ttl_zero_ff) begin
               verdict_in = VERDICT_TTL;
            end else if (dest_in != local_address_ff && dest_in[23:0] != BCAST_MASK) begin
               verdict_in = VERDICT_DEST;
            end else if (~sum_in != csum_in) begin
               verdict_in = VERDICT_CSUM;
            end else begin
               verdict_in = VERDICT_DELIVER;
            end
         end else begin
            byte_pos_in = byte_pos_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff     <= '0;
         header_words_ff <= '0;
         sum_ff          <= '0;
         high_byte_ff    <= '0;
         csum_ff         <= '0;
         dest_ff         <= '0;
         ttl_zero_ff     <= 1'b0;
         in_header_ff    <= 1'b0;
      end else if (advance) begin
         byte_pos_ff     <= byte_pos_in;
         header_words_ff <= header_words_in;
         sum_ff          <= sum_in;
         high_byte_ff    <= high_byte_in;
         csum_ff         <= csum_in;
         dest_ff         <= dest_in;
         ttl_zero_ff     <= ttl_zero_in;
         in_header_ff    <= in_header_in;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_chan.ready;
      if (advance & emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance & emit) begin
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.verdict = verdict_ff;

   a_header_len_valid : assert property (@(posedge clock) disable iff (reset)
      in_header_ff |-> header_words_ff >= MIN_IHL)
      else $error("header length below minimum while in header");

   a_pos_in_range : assert property (@(posedge clock) disable iff (reset)
      in_header_ff |-> (byte_pos_ff != '0) &&
                       ({1'b0, byte_pos_ff} < {1'b0, header_words_ff, 2'b00}))
      else $error("byte position outside header");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |-> !advance)
      else $error("pending verdict overwritten");

   a_verdict_code : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> verdict_ff <= VERDICT_CSUM)
      else $error("verdict code out of range");

endmodule
